// ===== src/can_afb_pkg.sv =====
// Shared types, constants and helpers for the CAN acceptance filter bank.
// No dependencies; used by every other file under src except can_afb_ram.
package can_afb_pkg;

  localparam int FILTER_SLOTS = 32;
  localparam int BUS_COUNT    = 3;

  localparam int HIT_W     = 32;
  localparam int RAM_DEPTH = (FILTER_SLOTS < HIT_W) ? FILTER_SLOTS : HIT_W;
  localparam int SLOT_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_MASK  = 2'd0,
    MODE_LIST  = 2'd1,
    MODE_RANGE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    FUNC_CLASSIFY = 1'b0,
    FUNC_WRITE    = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_PUSH  = 2'd3
  } state_t;

  typedef struct packed {
    logic [0:0]  func;
    logic [1:0]  bus_index;
    logic [28:0] ident;
    logic        extended;
    logic        remote;
    logic [3:0]  dlc;
    logic [4:0]  slot;
    logic [1:0]  load_mode;
    logic [1:0]  load_kind;
    logic [31:0] load_first;
    logic [31:0] load_second;
    logic        load_enable;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  payload_length;
    logic [1:0]  frame_kind;
    logic [31:0] hit_mask;
    logic        hit_any;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  bus;
    mode_t       mode;
    logic [1:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
  } filt_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_step;
    logic push;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [6:0] dlc_len(input logic [3:0] code);
    logic [6:0] len;
    case (code)
      4'd9:    len = 7'd12;
      4'd10:   len = 7'd16;
      4'd11:   len = 7'd20;
      4'd12:   len = 7'd24;
      4'd13:   len = 7'd32;
      4'd14:   len = 7'd48;
      4'd15:   len = 7'd64;
      default: len = {3'b000, code};
    endcase
    return len;
  endfunction

endpackage

// ===== src/can_afb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module can_afb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/can_afb_ctrl.sv =====
// Controller for the filter bank: sequences capture, slot scan and result push.
// Depends on can_afb_pkg.
module can_afb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [0:0]            in_func,
  output logic                  in_stall,
  output can_afb_pkg::dp_cmd_t  cmd,
  input  can_afb_pkg::dp_stat_t stat
);

  can_afb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= can_afb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      can_afb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_func == can_afb_pkg::FUNC_WRITE) begin
            state_nxt = can_afb_pkg::ST_PUSH;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = can_afb_pkg::ST_SCAN;
          end
        end
      end
      can_afb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = can_afb_pkg::ST_DRAIN;
        end
      end
      can_afb_pkg::ST_DRAIN: begin
        state_nxt = can_afb_pkg::ST_PUSH;
      end
      can_afb_pkg::ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = can_afb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = can_afb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/can_afb_dp.sv =====
// Datapath: filter table RAM, enable bits, slot compare, hit accumulation
// and output register. Depends on can_afb_pkg and can_afb_ram.
module can_afb_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  can_afb_pkg::in_word_t  in_word,
  input  can_afb_pkg::dp_cmd_t   cmd,
  output can_afb_pkg::dp_stat_t  stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output can_afb_pkg::out_word_t out_word
);

  localparam int SW = can_afb_pkg::SLOT_W;
  localparam int ND = can_afb_pkg::RAM_DEPTH;
  localparam int EW = $bits(can_afb_pkg::filt_entry_t);

  logic [ND-1:0]  en_r;
  logic [SW-1:0]  cnt_r;
  logic           rd_vld_r;
  logic [SW-1:0]  rd_idx_r;
  logic [ND-1:0]  hits_r;
  logic [1:0]     bus_r;
  logic [28:0]    id_r;
  logic [1:0]     kind_r;
  logic [6:0]     len_r;
  logic           out_valid_r;
  can_afb_pkg::out_word_t out_r;

  logic                     wr_ok;
  logic [EW-1:0]            wdata;
  logic [EW-1:0]            rdata;
  can_afb_pkg::filt_entry_t ent;
  can_afb_pkg::filt_entry_t new_ent;
  logic [31:0]              id32;
  logic                     test_ok;
  logic                     slot_hit;

  assign wr_ok = cmd.capture && (in_word.func == can_afb_pkg::FUNC_WRITE)
              && ({1'b0, in_word.slot} < 6'(ND))
              && ({2'b00, in_word.bus_index} < 4'(can_afb_pkg::BUS_COUNT));

  always_comb begin
    new_ent.bus    = in_word.bus_index;
    new_ent.mode   = can_afb_pkg::mode_t'(in_word.load_mode);
    new_ent.kind   = in_word.load_kind;
    new_ent.first  = in_word.load_first;
    new_ent.second = in_word.load_second;
  end
  assign wdata = new_ent;

  can_afb_ram #(
    .WIDTH (EW),
    .DEPTH (ND)
  ) u_table (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (in_word.slot[SW-1:0]),
    .wdata (wdata),
    .re    (cmd.scan_step),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  assign ent  = can_afb_pkg::filt_entry_t'(rdata);
  assign id32 = {3'b000, id_r};

  always_comb begin
    case (ent.mode)
      can_afb_pkg::MODE_MASK:  test_ok = (id32 & ent.first) == (ent.second & ent.first);
      can_afb_pkg::MODE_LIST:  test_ok = (id32 == ent.first)
                                      || ((ent.second != can_afb_pkg::ALL_ONES)
                                          && (id32 == ent.second));
      can_afb_pkg::MODE_RANGE: test_ok = (id32 >= ent.first) && (id32 <= ent.second);
      default:                 test_ok = 1'b0;
    endcase
  end

  assign slot_hit = rd_vld_r && en_r[rd_idx_r] && (ent.bus == bus_r)
                 && (ent.kind == kind_r) && test_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        en_r[in_word.slot[SW-1:0]] <= in_word.load_enable;
      end
      if (cmd.scan_start) begin
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        cnt_r <= cnt_r + SW'(1);
      end
      rd_vld_r <= cmd.scan_step;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.capture) begin
      bus_r  <= in_word.bus_index;
      id_r   <= in_word.ident;
      hits_r <= '0;
      if (in_word.func == can_afb_pkg::FUNC_WRITE) begin
        kind_r <= 2'd0;
        len_r  <= 7'd0;
      end else begin
        kind_r <= {in_word.remote, in_word.extended};
        len_r  <= can_afb_pkg::dlc_len(in_word.dlc);
      end
    end else if (slot_hit) begin
      hits_r[rd_idx_r] <= 1'b1;
    end
    if (cmd.push) begin
      out_r.payload_length <= len_r;
      out_r.frame_kind     <= kind_r;
      out_r.hit_mask       <= can_afb_pkg::HIT_W'(hits_r);
      out_r.hit_any        <= |hits_r;
    end
  end

  assign stat.scan_last = (cnt_r == SW'(ND - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_word       = out_r;

endmodule

// ===== src/can_acceptance_filter_bank.sv =====
// CAN acceptance filter bank top level: controller plus datapath.
// Depends on can_afb_pkg, can_afb_ctrl, can_afb_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one word per item.
//   func = write loads one filter slot (bus, mode, kind, two id words,
//   enable); func = classify matches a received frame against the bank.
//   Every item gives exactly one result word on out_valid / out_stall /
//   out_word: zero for a write, else DLC length, frame kind and hit bitmap.
//   Sequence: a write goes from acceptance to ST_PUSH; a classify
//   scans one slot per cycle through the table RAM's read port in ST_SCAN,
//   then passes ST_DRAIN and ST_PUSH before its result is registered.
//   One item is in work at a time: in_stall is high from acceptance until
//   the result is loaded into the output register, so no new item is taken
//   before the last one is through.
//   The output register holds a finished word while out_stall is high; the
//   next result is pushed into it as soon as it frees up.
//   Reset (rst_n low, synchronous) clears all enable bits, so no slot
//   matches until written; other table contents are left as they were.
module can_acceptance_filter_bank (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  can_afb_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output can_afb_pkg::out_word_t out_word
);

  can_afb_pkg::dp_cmd_t  cmd;
  can_afb_pkg::dp_stat_t stat;

  can_afb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_word.func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  can_afb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== src/can_afb_chk.sv =====
// Port-level checker for the CAN acceptance filter bank, bound to the top.
// Depends on can_afb_pkg and can_acceptance_filter_bank.
module can_afb_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input can_afb_pkg::out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_hit_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.hit_any == (out_word.hit_mask != 32'd0)))
    else $error("hit_any disagrees with hit_mask");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.payload_length <= 7'd64))
    else $error("payload length out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while first still in work");

endmodule

bind can_acceptance_filter_bank can_afb_chk u_chk (.*);

// ===== dv/can_afb_checker.sv =====
`timescale 1ns / 1ps
// Filter bank checker: mirrors the slot tables and predicts one result word
// per accepted input word, then compares result words in order. Uses can_afb_pkg.
module can_afb_checker
  import can_afb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending_count
);

  localparam int DLC_BYTES [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};

  logic [1:0]  bank_bus    [FILTER_SLOTS];
  mode_t       bank_mode   [FILTER_SLOTS];
  logic [1:0]  bank_kind   [FILTER_SLOTS];
  logic [31:0] bank_first  [FILTER_SLOTS];
  logic [31:0] bank_second [FILTER_SLOTS];
  logic        bank_en     [FILTER_SLOTS];

  out_word_t verdict_q [$];
  int        errors = 0;

  function automatic logic id_passes(int s, logic [31:0] id);
    logic [31:0] a;
    logic [31:0] b;
    a = bank_first[s];
    b = bank_second[s];
    case (bank_mode[s])
      MODE_MASK:  return (id & a) == (b & a);
      MODE_LIST:  return id == a || (b != ALL_ONES && id == b);
      MODE_RANGE: return id >= a && id <= b;
      default:    return 1'b0;
    endcase
  endfunction

  // applies a write to the mirror, or classifies a frame against it
  task automatic apply_word(input in_word_t w, output out_word_t v);
    logic [1:0]  kind;
    logic [31:0] id;
    int          s;
    v = '0;
    if (w.func == FUNC_WRITE) begin
      if (int'(w.slot) < FILTER_SLOTS && int'(w.bus_index) < BUS_COUNT) begin
        bank_bus[w.slot]    = w.bus_index;
        bank_mode[w.slot]   = mode_t'(w.load_mode);
        bank_kind[w.slot]   = w.load_kind;
        bank_first[w.slot]  = w.load_first;
        bank_second[w.slot] = w.load_second;
        bank_en[w.slot]     = w.load_enable;
      end
    end else begin
      kind = {w.remote, w.extended};
      id   = {3'b000, w.ident};
      if (int'(w.bus_index) < BUS_COUNT) begin
        for (s = 0; s < FILTER_SLOTS && s < 32; s++) begin
          if (bank_en[s] && bank_bus[s] == w.bus_index && bank_kind[s] == kind &&
              id_passes(s, id))
            v.hit_mask[s] = 1'b1;
        end
      end
      v.payload_length = 7'(DLC_BYTES[w.dlc]);
      v.frame_kind     = kind;
      v.hit_any        = |v.hit_mask;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t seen;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < FILTER_SLOTS; i++) bank_en[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = out_word;
        if (verdict_q.size() == 0) begin
          $error("result word 0x%0h with nothing expected", seen);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          check_field("payload_length", want.payload_length, seen.payload_length);
          check_field("frame_kind", want.frame_kind, seen.frame_kind);
          check_field("hit_mask", want.hit_mask, seen.hit_mask);
          check_field("hit_any", want.hit_any, seen.hit_any);
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(in_word, want);
        verdict_q.push_back(want);
      end
    end
    fail_count    <= errors;
    pending_count <= verdict_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the filter bank testbench: clock, reset, directed and random words,
// random stalls and the verdict. Uses can_afb_pkg, can_afb_checker and the RTL.
module testbench;
  import can_afb_pkg::*;

  localparam int RANDOM_WORDS   = 1200;
  localparam int IDLE_PCT       = 23;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [1:0] KIND_STD_DATA = 2'd0;
  localparam logic [1:0] KIND_EXT_DATA = 2'd1;
  localparam logic [1:0] KIND_STD_RTR  = 2'd2;
  localparam logic [1:0] KIND_EXT_RTR  = 2'd3;
  localparam logic [1:0] BAD_BUS       = 2'(BUS_COUNT);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      quiet     = 1'b0;

  int fail_count;
  int pending_count;
  int idle_cycles = 0;

  // what was loaded, used to aim frames at live filters
  logic [1:0]  sh_bus    [32];
  mode_t       sh_mode   [32];
  logic [1:0]  sh_kind   [32];
  logic [31:0] sh_first  [32];
  logic [31:0] sh_second [32];
  logic        sh_loaded [32] = '{default: 1'b0};
  int          loaded_slots [$];

  can_acceptance_filter_bank DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  can_afb_checker bank_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("can_acceptance_filter_bank verification failed");
      $finish;
    end
  end

  function automatic in_word_t noise_word();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  task automatic send_word(input in_word_t w);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_slot(input logic [4:0] slot, input logic [1:0] bus, input mode_t mode,
                           input logic [1:0] kind, input logic [31:0] a,
                           input logic [31:0] b, input logic en);
    in_word_t w;
    w             = noise_word();
    w.func        = FUNC_WRITE;
    w.slot        = slot;
    w.bus_index   = bus;
    w.load_mode   = mode;
    w.load_kind   = kind;
    w.load_first  = a;
    w.load_second = b;
    w.load_enable = en;
    if (int'(bus) < BUS_COUNT) begin
      sh_bus[slot]    = bus;
      sh_mode[slot]   = mode;
      sh_kind[slot]   = kind;
      sh_first[slot]  = a;
      sh_second[slot] = b;
      if (!sh_loaded[slot]) begin
        sh_loaded[slot] = 1'b1;
        loaded_slots.push_back(slot);
      end
    end
    send_word(w);
  endtask

  task automatic classify(input logic [1:0] bus, input logic [28:0] ident, input logic ext,
                          input logic rtr, input logic [3:0] dlc);
    in_word_t w;
    w           = noise_word();
    w.func      = FUNC_CLASSIFY;
    w.bus_index = bus;
    w.ident     = ident;
    w.extended  = ext;
    w.remote    = rtr;
    w.dlc       = dlc;
    send_word(w);
  endtask

  task automatic random_load();
    logic [1:0]  kind;
    logic [1:0]  bus;
    logic [31:0] span;
    logic [31:0] a;
    logic [31:0] b;
    mode_t       mode;
    int          roll;
    int          j;
    kind = 2'($urandom_range(0, 3));
    mode = mode_t'($urandom_range(0, 3));
    bus  = ($urandom_range(0, 19) == 0) ? BAD_BUS : 2'($urandom_range(0, BUS_COUNT - 1));
    span = kind[0] ? 32'h1FFF_FFFF : 32'h0000_07FF;
    a    = $urandom & span;
    b    = $urandom & span;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      a = $urandom;
      b = $urandom;
    end else if (roll < 30 && loaded_slots.size() != 0) begin
      // clone a live filter so several slots hit on one frame
      j    = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
      bus  = sh_bus[j];
      mode = sh_mode[j];
      kind = sh_kind[j];
      a    = sh_first[j];
      b    = sh_second[j];
    end else if (mode == MODE_LIST && roll < 50) begin
      b = ALL_ONES;
    end else if (mode == MODE_RANGE) begin
      b = a + $urandom_range(0, 4096);
      if (b < a) b = ALL_ONES;
      if (roll > 90) {a, b} = {b, a};
    end
    load_slot(5'($urandom_range(0, 31)), bus, mode, kind, a, b,
              $urandom_range(0, 99) < 85);
  endtask

  task automatic random_frame();
    int          s;
    logic [31:0] id;
    logic [31:0] hi;
    logic [1:0]  kind;
    if (loaded_slots.size() == 0 || $urandom_range(0, 99) < 25) begin
      classify(($urandom_range(0, 9) == 0) ? BAD_BUS : 2'($urandom_range(0, BUS_COUNT - 1)),
               29'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
    end else begin
      s    = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
      kind = sh_kind[s];
      id   = $urandom & 32'h1FFF_FFFF;
      case (sh_mode[s])
        MODE_MASK: id = (id & ~sh_first[s]) | (sh_second[s] & sh_first[s]);
        MODE_LIST: id = $urandom_range(0, 1) ? sh_second[s] : sh_first[s];
        MODE_RANGE: begin
          if (sh_first[s] <= sh_second[s] && sh_first[s] <= 32'h1FFF_FFFF) begin
            hi = (sh_second[s] > 32'h1FFF_FFFF) ? 32'h1FFF_FFFF : sh_second[s];
            id = sh_first[s] + $urandom_range(0, hi - sh_first[s]);
          end
        end
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) kind = kind ^ 2'($urandom_range(1, 3));
      classify(sh_bus[s], id[28:0], kind[0], kind[1], 4'($urandom));
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing enabled out of reset
    classify(2'd0, 29'd0, 1'b0, 1'b0, 4'd0);
    load_slot(5'd0, 2'd0, MODE_MASK, KIND_STD_DATA, 32'h7F0, 32'h120, 1'b1);
    classify(2'd0, 29'h125, 1'b0, 1'b0, 4'd15);
    // kind disagrees
    classify(2'd0, 29'h125, 1'b1, 1'b0, 4'd1);
    // list with unused second entry, top slot, widest id
    load_slot(5'd31, 2'd2, MODE_LIST, KIND_EXT_RTR, 32'h1FFF_FFFF, ALL_ONES, 1'b1);
    classify(2'd2, 29'h1FFF_FFFF, 1'b1, 1'b1, 4'd8);
    load_slot(5'd1, 2'd1, MODE_LIST, KIND_STD_RTR, 32'h10, 32'h20, 1'b1);
    classify(2'd1, 29'h20, 1'b0, 1'b1, 4'd7);
    load_slot(5'd2, 2'd1, MODE_RANGE, KIND_EXT_DATA, 32'h100, 32'h1FFF_FFFF, 1'b1);
    classify(2'd1, 29'h1FFF_FFFF, 1'b1, 1'b0, 4'd9);
    // empty range
    load_slot(5'd3, 2'd1, MODE_RANGE, KIND_EXT_DATA, 32'h500, 32'h400, 1'b1);
    classify(2'd1, 29'h450, 1'b1, 1'b0, 4'd12);
    load_slot(5'd4, 2'd0, MODE_NONE, KIND_STD_DATA, 32'h0, 32'h0, 1'b1);
    classify(2'd0, 29'h120, 1'b0, 1'b0, 4'd13);
    // bus out of range: write dropped, classify returns no hits
    load_slot(5'd5, BAD_BUS, MODE_MASK, KIND_STD_DATA, 32'h0, 32'h0, 1'b1);
    classify(BAD_BUS, 29'd0, 1'b0, 1'b0, 4'd14);
    // zero mask accepts everything; id wider than the std flag implies
    load_slot(5'd6, 2'd0, MODE_MASK, KIND_STD_DATA, 32'h0, ALL_ONES, 1'b1);
    classify(2'd0, 29'h1ABC_DEF, 1'b0, 1'b0, 4'd10);
    load_slot(5'd0, 2'd0, MODE_MASK, KIND_STD_DATA, 32'h7F0, 32'h120, 1'b0);
    classify(2'd0, 29'h125, 1'b0, 1'b0, 4'd11);
    load_slot(5'd7, 2'd0, MODE_MASK, KIND_STD_DATA, ALL_ONES, ALL_ONES, 1'b1);
    classify(2'd0, 29'd0, 1'b0, 1'b0, 4'd2);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      quiet <= (n >= 400 && n < 600);
      if ($urandom_range(0, 99) < 30) random_load();
      else random_frame();
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;

    // let the count of the last accepted word settle before waiting on it
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("can_acceptance_filter_bank verification clean");
    end else begin
      $display("can_acceptance_filter_bank verification failed");
    end
    $finish;
  end

endmodule
